// ===== sv/one_shot_timer_table_assert.svh =====
// Assertion macros shared by the timer table modules.
`ifndef ONE_SHOT_TIMER_TABLE_ASSERT_SVH
`define ONE_SHOT_TIMER_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define OSTT_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer table check failed");

// Next-cycle implication, checked out of reset.
`define OSTT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer table sequence check failed");

`endif

// ===== sv/ostt_pkg.sv =====
// Shared types and constants of the one-shot timer table.
`timescale 1ns / 1ps

package ostt_pkg;

  localparam int SLOT_COUNT_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int MAX_RESULTS     = 32;

  localparam int WORD_W    = 32;
  localparam int DELAY_W   = 16;
  localparam int SLOT_IN_W = 8;
  localparam int FIRED_W   = 5;
  localparam int REQ_W     = 2;
  localparam int ENTRY_W   = 2 * WORD_W;

  localparam logic [REQ_W-1:0] REQ_SET   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_SET,
    OP_TICK,
    OP_CLEAR
  } op_t;

  // stamp holds the deadline for a set and the current time for a tick
  typedef struct packed {
    op_t                  op;
    logic [SLOT_IN_W-1:0] index;
    logic [WORD_W-1:0]    payload;
    logic [WORD_W-1:0]    stamp;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_rd_t;

endpackage

// ===== sv/one_shot_timer_table.sv =====
// Top level of the one-shot timer table.
`timescale 1ns / 1ps

// One-shot timer table. Each of SLOT_COUNT slots holds a 32-bit data word and an
// absolute deadline, where deadline zero means idle. A set word stores the data and
// now_time + delay_ticks (mod 2^32) into a slot, then rescans the table for the
// earliest deadline. A tick whose now_time has not reached the earliest deadline and
// a clear are handled without a scan; a set to an out-of-range slot is dropped by the
// decoder and never queued. A tick that fires makes two passes over the slots: the
// first finds the next deadline and the final reported slot, the second reports the
// expired slots in rising index order (at most 32 words per tick) and clears every
// expired slot, stalling while the output register is held. The pace is set by the
// single read port of the slot RAM, read once per slot per pass with registered
// data. A short command queue sits in front of the scan engine, so input words keep
// being taken while a scan runs, until the queue fills; one output register holds
// the current word while the engine moves on to the next slot.

module one_shot_timer_table import ostt_pkg::*; #(
  parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request word
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [REQ_W-1:0]         in_req_type,
  input  logic [SLOT_IN_W-1:0]     in_slot_index,
  input  logic signed [WORD_W-1:0] in_slot_payload,
  input  logic [DELAY_W-1:0]       in_delay_ticks,
  input  logic [WORD_W-1:0]        in_now_time,
  // expiry word
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [FIRED_W-1:0]       out_fired_slot,
  output logic signed [WORD_W-1:0] out_fired_payload,
  output logic [WORD_W-1:0]        out_next_deadline,
  output logic                     out_last_of_run
);

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  // decode: compute set deadlines, drop words that do nothing
  ostt_front #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_slot_index   (in_slot_index),
    .in_slot_payload (in_slot_payload),
    .in_delay_ticks  (in_delay_ticks),
    .in_now_time     (in_now_time),
    .q_full          (q_full),
    .q_wr            (q_wr)
  );

  // decouple decode from the scan so each side stalls on its own
  ostt_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  // slot store, earliest deadline and expiry reporting
  ostt_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_rd              (q_rd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_fired_slot    (out_fired_slot),
    .out_fired_payload (out_fired_payload),
    .out_next_deadline (out_next_deadline),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

// ===== sv/ostt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ostt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/ostt_front.sv =====
// Request decoder: classifies incoming words into queue commands.
`timescale 1ns / 1ps

module ostt_front import ostt_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [REQ_W-1:0]            in_req_type,
  input  logic [SLOT_IN_W-1:0]        in_slot_index,
  input  logic signed [WORD_W-1:0]    in_slot_payload,
  input  logic [DELAY_W-1:0]          in_delay_ticks,
  input  logic [WORD_W-1:0]           in_now_time,
  input  logic                        q_full,
  output q_wr_t                       q_wr
);

  logic keep;
  logic in_range;

  assign in_range = {1'b0, in_slot_index} < (SLOT_IN_W + 1)'(SLOT_COUNT);

  always_comb begin
    keep            = 1'b0;
    q_wr.cmd.op      = OP_TICK;
    q_wr.cmd.index   = in_slot_index;
    q_wr.cmd.payload = in_slot_payload;
    q_wr.cmd.stamp   = in_now_time;
    unique case (in_req_type)
      REQ_SET: begin
        keep           = in_range;
        q_wr.cmd.op    = OP_SET;
        q_wr.cmd.stamp = in_now_time + WORD_W'(in_delay_ticks);
      end
      REQ_TICK: begin
        keep = 1'b1;
      end
      REQ_CLEAR: begin
        keep        = 1'b1;
        q_wr.cmd.op = OP_CLEAR;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    // drop out-of-range sets and unknown codes: accepted, never queued
    q_wr.push = in_valid && !q_full && keep;
  end

  assign in_stall = q_full;

endmodule

// ===== sv/ostt_fifo.sv =====
// Short command queue between the decoder and the scan engine.
`timescale 1ns / 1ps

`include "one_shot_timer_table_assert.svh"

module ostt_fifo import ostt_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  q_wr_t q_wr,
  output logic  q_full,
  output q_rd_t q_rd,
  input  logic  q_pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t            mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_pop;

  assign q_full     = (count_r == CW'(DEPTH));
  assign q_rd.valid = (count_r != '0);
  assign q_rd.cmd   = mem_r[rd_ptr_r];
  assign do_pop     = q_pop && q_rd.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_wr.push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({q_wr.push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem_r[wr_ptr_r] <= q_wr.cmd;
    end
  end

  `OSTT_CHECK(a_no_push_when_full, q_wr.push, count_r != CW'(DEPTH))

endmodule

// ===== sv/ostt_back.sv =====
// Scan engine: slot store, earliest-deadline tracking and expiry reporting.
`timescale 1ns / 1ps

`include "one_shot_timer_table_assert.svh"

module ostt_back import ostt_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  q_rd_t                    q_rd,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [FIRED_W-1:0]       out_fired_slot,
  output logic signed [WORD_W-1:0] out_fired_payload,
  output logic [WORD_W-1:0]        out_next_deadline,
  output logic                     out_last_of_run
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN1 = 3'b010,
    ST_SCAN2 = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   ph_r, ph_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [IDX_W-1:0]       last_idx_r, last_idx_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  op_t                    op_r, op_nxt;
  logic [WORD_W-1:0]      now_r, now_nxt;
  logic [WORD_W-1:0]      min_r, min_nxt;
  logic [WORD_W-1:0]      earliest_r, earliest_nxt;
  logic [SLOT_COUNT-1:0]  valid_r, valid_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [FIRED_W-1:0]     out_slot_r;
  logic [WORD_W-1:0]      out_data_r;
  logic [WORD_W-1:0]      out_next_r;
  logic                   out_last_r;

  logic                   ram_we;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic [WORD_W-1:0]      d_cur;
  logic [WORD_W-1:0]      data_cur;
  logic [WORD_W-1:0]      min_upd;
  logic                   expired;
  logic                   live;
  logic                   report;
  logic                   last_slot;
  logic                   out_free;
  logic                   out_load;

  // entry layout: payload above deadline
  assign ram_we    = q_pop && (q_rd.cmd.op == OP_SET);
  assign ram_wdata = {q_rd.cmd.payload, q_rd.cmd.stamp};

  ostt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (q_rd.cmd.index[IDX_W-1:0]),
    .wr_data (ram_wdata),
    .rd_addr (idx_r),
    .rd_data (ram_rdata)
  );

  // a slot never written since reset or clear reads as idle
  assign d_cur     = valid_r[idx_r] ? ram_rdata[WORD_W-1:0] : '0;
  assign data_cur  = ram_rdata[ENTRY_W-1:WORD_W];
  assign expired   = (d_cur != '0) && (d_cur <= now_r);
  assign live      = (d_cur != '0) && !expired;
  assign min_upd   = (live && ((min_r == '0) || (d_cur < min_r))) ? d_cur : min_r;
  assign report    = (cnt_r < CNT_W'(MAX_RESULTS));
  assign last_slot = (idx_r == IDX_W'(SLOT_COUNT - 1));
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    idx_nxt       = idx_r;
    last_idx_nxt  = last_idx_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    now_nxt       = now_r;
    min_nxt       = min_r;
    earliest_nxt  = earliest_r;
    valid_nxt     = valid_r;
    q_pop         = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_rd.valid) begin
          q_pop = 1'b1;
          case (q_rd.cmd.op)
            OP_SET: begin
              valid_nxt[q_rd.cmd.index[IDX_W-1:0]] = 1'b1;
              op_nxt    = OP_SET;
              now_nxt   = '0;
              min_nxt   = '0;
              cnt_nxt   = '0;
              idx_nxt   = '0;
              ph_nxt    = 1'b0;
              state_nxt = ST_SCAN1;
            end
            OP_TICK: begin
              if ((earliest_r != '0) && (earliest_r <= q_rd.cmd.stamp)) begin
                op_nxt    = OP_TICK;
                now_nxt   = q_rd.cmd.stamp;
                min_nxt   = '0;
                cnt_nxt   = '0;
                idx_nxt   = '0;
                ph_nxt    = 1'b0;
                state_nxt = ST_SCAN1;
              end
            end
            OP_CLEAR: begin
              valid_nxt    = '0;
              earliest_nxt = '0;
            end
            default: begin
              valid_nxt = valid_r;
            end
          endcase
        end
      end
      ST_SCAN1: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt  = 1'b0;
          min_nxt = min_upd;
          if (expired && report) begin
            cnt_nxt      = cnt_r + 1'b1;
            last_idx_nxt = idx_r;
          end
          if (last_slot) begin
            earliest_nxt = min_upd;
            idx_nxt      = '0;
            cnt_nxt      = '0;
            state_nxt    = (op_r == OP_TICK) ? ST_SCAN2 : ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_SCAN2: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else if (!(expired && report && !out_free)) begin
          if (expired) begin
            valid_nxt[idx_r] = 1'b0;
            if (report) begin
              out_load = 1'b1;
              cnt_nxt  = cnt_r + 1'b1;
            end
          end
          ph_nxt = 1'b0;
          if (last_slot) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= 1'b0;
      idx_r       <= '0;
      last_idx_r  <= '0;
      cnt_r       <= '0;
      op_r        <= OP_SET;
      now_r       <= '0;
      min_r       <= '0;
      earliest_r  <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      idx_r       <= idx_nxt;
      last_idx_r  <= last_idx_nxt;
      cnt_r       <= cnt_nxt;
      op_r        <= op_nxt;
      now_r       <= now_nxt;
      min_r       <= min_nxt;
      earliest_r  <= earliest_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_slot_r <= FIRED_W'(idx_r);
      out_data_r <= data_cur;
      out_next_r <= min_r;
      out_last_r <= (idx_r == last_idx_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fired_slot    = out_slot_r;
  assign out_fired_payload = out_data_r;
  assign out_next_deadline = out_next_r;
  assign out_last_of_run   = out_last_r;

  `OSTT_CHECK(a_pop_only_idle, q_pop, state_r == ST_IDLE)
  `OSTT_CHECK(a_report_only_tick, state_r == ST_SCAN2, op_r == OP_TICK)
  `OSTT_NEXT(a_fired_slot_cleared, out_load, !valid_r[$past(idx_r)])

endmodule
